// ----- hw/rtl/sfr_pkg.sv -----
// package for the string find and replace core
// segment codes, length limits and shared types; no dependencies
`default_nettype none

package sfr_pkg;

  localparam int unsigned MAX_LEN = 8;

  localparam logic [1:0] SEG_HEAD = 2'd0;
  localparam logic [1:0] SEG_BYTE = 2'd1;
  localparam logic [1:0] SEG_REPL = 2'd2;
  localparam logic [1:0] SEG_TAIL = 2'd3;

  localparam logic [1:0] REG_PATTERN_LEN   = 2'd0;
  localparam logic [1:0] REG_REPLACE_LEN   = 2'd1;
  localparam logic [1:0] REG_PATTERN_BYTES = 2'd2;
  localparam logic [1:0] REG_REPLACE_BYTES = 2'd3;

  typedef logic [3:0][3:0] seg_lens_t;

  function automatic logic [1:0] first_seg(input logic [1:0] from, input seg_lens_t lens);
    logic [1:0] s;
    s = SEG_TAIL;
    for (int i = 3; i >= 0; i--) begin
      if (i >= int'(from) && lens[i] != 4'd0) begin
        s = 2'(i);
      end
    end
    return s;
  endfunction

  function automatic logic [3:0] clamp_len(input logic [3:0] v, input logic [3:0] lo);
    logic [3:0] r;
    r = v;
    if (v < lo) begin
      r = lo;
    end else if (v > 4'(MAX_LEN)) begin
      r = 4'(MAX_LEN);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/string_find_replace_core.sv -----
// string find and replace core: streams text bytes and substitutes pattern matches
// depends on sfr_pkg
`default_nettype none

// Each accepted byte is classified against the match state and registered,
// then the core emits the resulting items one per cycle (up to eight) while
// the output is not stalled, from a single byte selector walking the
// held-prefix, passed-byte, replacement and end-flush segments. A transaction
// yields 0 to 8 result items, or one end marker; in_tready is low while items
// are being emitted. Configuration writes are always accepted and must only
// happen while the core is idle. Only the count of matched pattern bytes is
// kept; held bytes are replayed from the pattern register.
module string_find_replace_core
  import sfr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] in_byte
  input  wire logic        in_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // [7:0] out_byte
  output logic             out_tuser,  // [0] has_char
  output logic             out_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic        state_r, state_nxt;
  logic [3:0]  pattern_len_r, pattern_len_nxt;
  logic [3:0]  replace_len_r, replace_len_nxt;
  logic [63:0] pattern_bytes_r, pattern_bytes_nxt;
  logic [63:0] replace_bytes_r, replace_bytes_nxt;
  logic [3:0]  mc_r, mc_nxt;
  seg_lens_t   lens_r, lens_nxt;
  logic [1:0]  seg_r, seg_nxt;
  logic [2:0]  idx_r, idx_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [3:0]  total_r, total_nxt;
  logic        marker_r, marker_nxt;
  logic [7:0]  byte_r, byte_nxt;
  logic        text_last_r, text_last_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_byte_r, out_byte_nxt;
  logic        out_char_r, out_char_nxt;
  logic        out_last_r, out_last_nxt;

  logic        in_acc;
  logic        load_en;
  logic [3:0]  plen, rlen;
  logic        hit0, hitk, advance, matched;
  logic [3:0]  mc_adv, mc_new;
  logic [3:0]  n_head, n_repl, n_tail;
  logic        n_byte;
  logic [4:0]  sum;
  logic [3:0]  total;
  logic        last_item;
  logic [7:0]  sel_byte;
  seg_lens_t   lens;

  assign in_tready  = (state_r == ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign in_acc     = in_tvalid && in_tready;
  assign load_en    = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tuser  = out_char_r;
  assign out_tlast  = out_last_r;

  // classify the incoming byte against the match state
  always_comb begin
    plen    = clamp_len(pattern_len_r, 4'd1);
    rlen    = clamp_len(replace_len_r, 4'd0);
    hit0    = (in_tdata == pattern_bytes_r[7:0]);
    hitk    = (mc_r != 4'd0) && (mc_r < 4'(MAX_LEN)) &&
              (in_tdata == pattern_bytes_r[mc_r[2:0]*8 +: 8]);
    advance = hit0 || hitk;
    mc_adv  = hit0 ? 4'd1 : mc_r + 4'd1;
    matched = advance && (mc_adv >= plen);
    n_head  = (hit0 || !advance) ? mc_r : 4'd0;
    n_byte  = !advance;
    n_repl  = matched ? rlen : 4'd0;
    mc_new  = (advance && !matched) ? mc_adv : 4'd0;
    n_tail  = in_tlast ? mc_new : 4'd0;
    sum     = {1'b0, n_head} + {4'b0, n_byte} + {1'b0, n_repl} + {1'b0, n_tail};
    total   = (sum > 5'(MAX_LEN)) ? 4'(MAX_LEN) : sum[3:0];
    lens[SEG_HEAD] = n_head;
    lens[SEG_BYTE] = {3'b0, n_byte};
    lens[SEG_REPL] = n_repl;
    lens[SEG_TAIL] = n_tail;
  end

  // shared byte selector
  always_comb begin
    case (seg_r)
      SEG_HEAD: sel_byte = pattern_bytes_r[idx_r*8 +: 8];
      SEG_BYTE: sel_byte = byte_r;
      SEG_REPL: sel_byte = replace_bytes_r[idx_r*8 +: 8];
      SEG_TAIL: sel_byte = pattern_bytes_r[idx_r*8 +: 8];
      default:  sel_byte = 8'd0;
    endcase
    last_item = marker_r || ((cnt_r + 4'd1) == total_r);
  end

  always_comb begin
    state_nxt         = state_r;
    pattern_len_nxt   = pattern_len_r;
    replace_len_nxt   = replace_len_r;
    pattern_bytes_nxt = pattern_bytes_r;
    replace_bytes_nxt = replace_bytes_r;
    mc_nxt            = mc_r;
    lens_nxt          = lens_r;
    seg_nxt           = seg_r;
    idx_nxt           = idx_r;
    cnt_nxt           = cnt_r;
    total_nxt         = total_r;
    marker_nxt        = marker_r;
    byte_nxt          = byte_r;
    out_valid_nxt     = out_valid_r && !out_tready;
    out_byte_nxt      = out_byte_r;
    out_char_nxt      = out_char_r;
    out_last_nxt      = out_last_r;

    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PATTERN_LEN:   pattern_len_nxt   = cfg_data[3:0];
        REG_REPLACE_LEN:   replace_len_nxt   = cfg_data[3:0];
        REG_PATTERN_BYTES: pattern_bytes_nxt = cfg_data;
        REG_REPLACE_BYTES: replace_bytes_nxt = cfg_data;
        default: ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          mc_nxt     = in_tlast ? 4'd0 : mc_new;
          lens_nxt   = lens;
          seg_nxt    = first_seg(SEG_HEAD, lens);
          idx_nxt    = 3'd0;
          cnt_nxt    = 4'd0;
          total_nxt  = total;
          marker_nxt = in_tlast && (total == 4'd0);
          byte_nxt   = in_tdata;
          if (total != 4'd0 || in_tlast) begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (load_en) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = marker_r ? 8'd0 : sel_byte;
          out_char_nxt  = !marker_r;
          out_last_nxt  = last_item && (marker_r || text_last_r);
          if (last_item) begin
            state_nxt = ST_IDLE;
          end else begin
            cnt_nxt = cnt_r + 4'd1;
            if (({1'b0, idx_r} + 4'd1) == lens_r[seg_r]) begin
              seg_nxt = first_seg(seg_r + 2'd1, lens_r);
              idx_nxt = 3'd0;
            end else begin
              idx_nxt = idx_r + 3'd1;
            end
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    text_last_nxt = text_last_r;
    if (in_acc) begin
      text_last_nxt = in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      pattern_len_r <= 4'd1;
      replace_len_r <= 4'd0;
      pattern_bytes_r <= 64'd0;
      replace_bytes_r <= 64'd0;
      mc_r          <= 4'd0;
      out_valid_r   <= 1'b0;
      marker_r      <= 1'b0;
      cnt_r         <= 4'd0;
      total_r       <= 4'd0;
      text_last_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      pattern_len_r <= pattern_len_nxt;
      replace_len_r <= replace_len_nxt;
      pattern_bytes_r <= pattern_bytes_nxt;
      replace_bytes_r <= replace_bytes_nxt;
      mc_r          <= mc_nxt;
      out_valid_r   <= out_valid_nxt;
      marker_r      <= marker_nxt;
      cnt_r         <= cnt_nxt;
      total_r       <= total_nxt;
      text_last_r   <= text_last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lens_r     <= lens_nxt;
    seg_r      <= seg_nxt;
    idx_r      <= idx_nxt;
    byte_r     <= byte_nxt;
    out_byte_r <= out_byte_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

`ifndef SYNTHESIS
  a_match_count_range : assert property (@(posedge clk) disable iff (!rst_n)
    mc_r < 4'(MAX_LEN))
    else $error("matched count out of range");

  a_marker_is_last : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> out_tlast)
    else $error("end marker without last flag");

  a_count_below_total : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && !marker_r) |-> (cnt_r < total_r))
    else $error("emit count passed item total");
`endif

endmodule

`default_nettype wire

// ----- bench/string_find_replace_core_test.sv -----
// testbench for string_find_replace_core: streams texts, predicts the substituted output
// and checks every result transaction; depends on sfr_pkg and the core
`timescale 1ns / 1ps

module string_find_replace_core_test
  import sfr_pkg::*;
();

  typedef struct packed {
    logic [7:0] ch;
    logic       has_char;
    logic       last;
  } text_item_t;

  class text_scoreboard;
    logic [3:0]  pat_len_reg;
    logic [3:0]  rep_len_reg;
    logic [63:0] pat_reg;
    logic [63:0] rep_reg;
    logic [3:0]  held;
    text_item_t  step_q[$];
    text_item_t  expected_text[$];
    int          errors;

    function new();
      pat_len_reg = 4'd1;
      rep_len_reg = 4'd0;
      pat_reg = '0;
      rep_reg = '0;
      held = '0;
      errors = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [63:0] val);
      case (idx)
        REG_PATTERN_LEN:   pat_len_reg = val[3:0];
        REG_REPLACE_LEN:   rep_len_reg = val[3:0];
        REG_PATTERN_BYTES: pat_reg = val;
        REG_REPLACE_BYTES: rep_reg = val;
        default: ;
      endcase
    endfunction

    function void emit_char(logic [7:0] b);
      text_item_t it;
      it.ch = b;
      it.has_char = 1'b1;
      it.last = 1'b0;
      if (step_q.size() < 8) step_q.push_back(it);
    endfunction

    function void flush_prefix();
      for (int i = 0; i < held; i++) emit_char(pat_reg[8*i +: 8]);
      held = '0;
    endfunction

    function void take_in_byte(logic [7:0] b, logic last);
      int unsigned plen;
      int unsigned rlen;
      logic advance;
      text_item_t marker;
      plen = (pat_len_reg == 0) ? 1 : (pat_len_reg > 8) ? 8 : pat_len_reg;
      rlen = (rep_len_reg > 8) ? 8 : rep_len_reg;
      step_q = {};
      if (b == pat_reg[7:0]) begin
        flush_prefix();
        advance = 1'b1;
      end else if (held > 0 && held < 8 && b == pat_reg[8*held +: 8]) begin
        advance = 1'b1;
      end else begin
        flush_prefix();
        emit_char(b);
        advance = 1'b0;
      end
      if (advance) begin
        held = held + 4'd1;
        if (held >= plen) begin
          held = '0;
          for (int i = 0; i < rlen; i++) emit_char(rep_reg[8*i +: 8]);
        end
      end
      if (last) begin
        flush_prefix();
        if (step_q.size() == 0) begin
          marker.ch = 8'h00;
          marker.has_char = 1'b0;
          marker.last = 1'b1;
          step_q.push_back(marker);
        end else begin
          step_q[step_q.size()-1].last = 1'b1;
        end
      end
      foreach (step_q[i]) expected_text.push_back(step_q[i]);
    endfunction

    function void check_out_item(logic [7:0] ch, logic has_char, logic last);
      text_item_t want;
      if (expected_text.size() == 0) begin
        $display("%0t: unexpected output, got byte %h has_char %b last %b",
                 $time, ch, has_char, last);
        errors++;
      end else begin
        want = expected_text.pop_front();
        if (want.ch !== ch || want.has_char !== has_char || want.last !== last) begin
          $display("%0t: output mismatch, expected byte %h has_char %b last %b, got %h %b %b",
                   $time, want.ch, want.has_char, want.last, ch, has_char, last);
          errors++;
        end
      end
    endfunction

    function int outstanding();
      return expected_text.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        out_tuser;
  logic        out_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;

  text_scoreboard sb;
  int          send_idle = 20;
  int          recv_idle = 78;
  int          hold_left = 0;
  int          random_items = 0;
  int unsigned cur_plen = 1;
  logic [63:0] cur_pat = '0;

  string_find_replace_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial forever #1 clk = ~clk;

  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // receiver side, with an optional long hold-off
  initial forever begin
    @(posedge clk);
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    if (rst_n && sb != null) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (out_tvalid && out_tready) sb.check_out_item(out_tdata, out_tuser, out_tlast);
      if (in_tvalid && in_tready) sb.take_in_byte(in_tdata, in_tlast);
    end
  end

  function automatic logic [63:0] wide_random();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] two_letter_pattern();
    logic [63:0] p;
    for (int i = 0; i < 8; i++) p[8*i +: 8] = 8'h61 + 8'($urandom_range(1));
    return p;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tlast <= last;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic apply_setting(input logic [3:0] plen, input logic [3:0] rlen,
                               input logic [63:0] pat, input logic [63:0] rep);
    logic [63:0] v;
    wait_idle();
    v = wide_random();
    v[3:0] = plen;
    write_reg(REG_PATTERN_LEN, v);
    v = wide_random();
    v[3:0] = rlen;
    write_reg(REG_REPLACE_LEN, v);
    write_reg(REG_PATTERN_BYTES, pat);
    write_reg(REG_REPLACE_BYTES, rep);
    cfg_valid <= 1'b0;
    cur_plen = (plen == 0) ? 1 : (plen > 8) ? 8 : plen;
    cur_pat = pat;
  endtask

  // text built mostly from whole and partial pattern copies, plus noise
  task automatic send_text(input int chunks);
    logic [7:0] text_q[$];
    int kind;
    int n;
    for (int c = 0; c < chunks; c++) begin
      kind = $urandom_range(99);
      if (kind < 35) n = cur_plen;
      else if (kind < 60) n = $urandom_range(cur_plen, 1);
      else n = 0;
      for (int i = 0; i < n; i++) text_q.push_back(cur_pat[8*i +: 8]);
      if (kind >= 80) text_q.push_back(8'($urandom()));
      else if (kind >= 60) text_q.push_back(cur_pat[8*$urandom_range(7, 0) +: 8]);
    end
    foreach (text_q[i]) send_byte(text_q[i], i == text_q.size() - 1);
    random_items += text_q.size();
  endtask

  initial begin
    sb = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset configuration: one zero byte pattern, empty replacement
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);

    apply_setting(4'd3, 4'd2, 64'h0000_0000_0063_6261, 64'h0000_0000_0000_5958);
    send_byte(8'h61, 1'b0);
    send_byte(8'h62, 1'b0);
    send_byte(8'h63, 1'b1);
    send_byte(8'h61, 1'b0);
    send_byte(8'h62, 1'b1);

    // shorten the pattern while two bytes are held
    send_byte(8'h61, 1'b0);
    send_byte(8'h62, 1'b0);
    apply_setting(4'd2, 4'd2, 64'h0000_0000_0063_6261, 64'h0000_0000_0000_5958);
    send_byte(8'h63, 1'b0);
    send_byte(8'h7A, 1'b1);

    // restart on first byte with held prefix; replacement output capped at eight items
    apply_setting(4'd8, 4'd8, 64'h6867_6665_6463_6261, wide_random());
    send_byte(8'h61, 1'b0);
    send_byte(8'h62, 1'b0);
    send_byte(8'h63, 1'b0);
    apply_setting(4'd1, 4'd8, 64'h6867_6665_6463_6261, wide_random());
    send_byte(8'h61, 1'b1);

    // out of range lengths
    apply_setting(4'd0, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF, wide_random());
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b1);
    apply_setting(4'd15, 4'd0, wide_random(), wide_random());
    for (int i = 0; i < 8; i++) send_byte(cur_pat[8*i +: 8], i == 7);

    for (int s = 0; s < 9; s++) begin
      case (s)
        0: apply_setting(4'd1, 4'd0, wide_random(), wide_random());
        1: apply_setting(4'd3, 4'd2, two_letter_pattern(), wide_random());
        2: apply_setting(4'd8, 4'd8, wide_random(), wide_random());
        3: apply_setting(4'd0, 4'd8, two_letter_pattern(), wide_random());
        4: apply_setting(4'd15, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF, wide_random());
        5: apply_setting(4'd2, 4'd1, two_letter_pattern(), wide_random());
        6: apply_setting(4'($urandom_range(8, 1)), 4'($urandom_range(8)),
                         two_letter_pattern(), wide_random());
        7: apply_setting(4'($urandom_range(15)), 4'($urandom_range(15)),
                         wide_random(), wide_random());
        default: apply_setting(4'd4, 4'd3, two_letter_pattern(), wide_random());
      endcase
      if (s == 1) begin
        // output held off while input keeps coming
        hold_left = 300;
        send_idle = 0;
        send_text(12);
      end
      while (random_items < 470 * (s + 1) / 9) begin
        if (random_items < 157) begin
          send_idle = 20;
          recv_idle = 78;
        end else if (random_items < 314) begin
          send_idle = 78;
          recv_idle = 20;
        end else begin
          send_idle = 0;
          recv_idle = 0;
        end
        send_text($urandom_range(6, 1));
      end
    end

    wait_idle();
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/sfr_pkg.sv
hw/rtl/string_find_replace_core.sv
bench/string_find_replace_core_test.sv
